// File: hw/rtl/group_reverse_stream_macros.svh
// Assertion helpers for the checks inside the group_reverse_stream module.
`ifndef GROUP_REVERSE_STREAM_MACROS_SVH
`define GROUP_REVERSE_STREAM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/grs_pkg.sv
package grs_pkg;

    // Default buffer depth and data width.
    localparam int MAX_GROUP_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 16;

    // Width of the group size register.
    localparam int CFG_WIDTH = 5;

endpackage

// File: hw/rtl/group_reverse_stream.sv
// Channel      | Direction | Contents
// -------------+-----------+--------------------------------------------------
// s_axis       | in        | tdata: value; tlast: seq_end
// m_axis       | out       | tdata: out_value; tlast: run_last; tuser: list_end
// cfg          | in        | data: group_size (5 bits)
//
// An item that does not complete a group is taken and written to the group
// buffer. An item that closes a group (or ends the sequence) starts a drain
// of n results, one per cycle through the buffer's single read port; input
// is held off until the drain ends. Output back-pressure stalls the drain.
// Reset is synchronous and active low; the buffer needs no clearing, since
// only entries written in the current group are read back.
module group_reverse_stream
    import grs_pkg::*;
#(
    parameter int MAX_GROUP  = MAX_GROUP_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_WIDTH-1:0] s_axis_tdata,   // [DATA_WIDTH-1:0] value
    input  logic                  s_axis_tlast,   // seq_end
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_WIDTH-1:0] m_axis_tdata,   // [DATA_WIDTH-1:0] out_value
    output logic                  m_axis_tlast,   // run_last
    output logic                  m_axis_tuser,   // [0] list_end
    // Group size register.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_WIDTH-1:0]  i_cfg_data
);

`include "group_reverse_stream_macros.svh"

    // Buffer address width and the width of a count that can reach MAX_GROUP.
    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int SW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                 r_state, n_state;
    logic [CFG_WIDTH-1:0] r_gsize;
    logic [CW-1:0]        r_fill, n_fill;
    logic [AW-1:0]        r_addr, n_addr;
    logic [CW-1:0]        r_remain, n_remain;
    logic                 r_rev, n_rev;
    logic                 r_end, n_end;
    logic                 r_ovalid, n_ovalid;
    logic                 r_olast, n_olast;
    logic                 r_oend, n_oend;

    logic                 w_in_acc;
    logic                 w_issue;
    logic [CW-1:0]        w_n;
    logic [SW-1:0]        w_k;
    logic                 w_full;
    logic [DATA_WIDTH-1:0] w_rdata;

    // The register takes every write offered; the size is only looked at when
    // an item is taken, so a new value applies from the next item on.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsize <= CFG_WIDTH'(1);
        end else if (i_cfg_valid) begin
            r_gsize <= i_cfg_data;
        end
    end

    // A size of zero acts as one; sizes beyond the buffer saturate to its depth.
    always_comb begin
        if (r_gsize == '0) begin
            w_k = SW'(1);
        end else if (SW'(r_gsize) > SW'(MAX_GROUP)) begin
            w_k = SW'(MAX_GROUP);
        end else begin
            w_k = SW'(r_gsize);
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_n           = r_fill + CW'(1);
    assign w_full        = (SW'(w_n) >= w_k);

    // A read is issued only when the output register is free or being emptied.
    assign w_issue = (r_state == ST_DRAIN) && (!r_ovalid || m_axis_tready);

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_addr   = r_addr;
        n_remain = r_remain;
        n_rev    = r_rev;
        n_end    = r_end;
        n_ovalid = r_ovalid;
        n_olast  = r_olast;
        n_oend   = r_oend;

        if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        // Complete group: read it back newest first.
                        n_state  = ST_DRAIN;
                        n_addr   = r_fill[AW-1:0];
                        n_remain = w_n;
                        n_rev    = 1'b1;
                        n_end    = s_axis_tlast;
                        n_fill   = '0;
                    end else if (s_axis_tlast) begin
                        // Short tail at the end of the sequence: arrival order.
                        n_state  = ST_DRAIN;
                        n_addr   = '0;
                        n_remain = w_n;
                        n_rev    = 1'b0;
                        n_end    = 1'b1;
                        n_fill   = '0;
                    end else begin
                        n_fill = w_n;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_issue) begin
                    n_ovalid = 1'b1;
                    n_olast  = (r_remain == CW'(1));
                    n_oend   = r_end && (r_remain == CW'(1));
                    n_addr   = r_rev ? (r_addr - AW'(1)) : (r_addr + AW'(1));
                    n_remain = r_remain - CW'(1);
                    if (r_remain == CW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_remain <= '0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_ovalid <= n_ovalid;
            r_remain <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_rev   <= n_rev;
        r_end   <= n_end;
        r_olast <= n_olast;
        r_oend  <= n_oend;
    end

    // The read data register doubles as the output payload register: it only
    // changes on a new read, which happens only when the output is free or being emptied.
    grs_buf #(
        .DEPTH (MAX_GROUP),
        .DW    (DATA_WIDTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (w_issue),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = w_rdata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oend;

    // The held count always leaves room for the next item in the buffer.
    `GRS_ASSERT_NOW(a_fill_room, 1'b1, r_fill < CW'(MAX_GROUP), "fill count reached depth")
    // An item that closes a group or ends the sequence always starts a drain.
    `GRS_ASSERT_NEXT(a_drain_start, w_in_acc && (w_full || s_axis_tlast),
        r_state == ST_DRAIN && r_fill == '0, "drain did not start")
    // The end-of-sequence flag only rides on the last result of a run.
    `GRS_ASSERT_NOW(a_end_on_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast,
        "list_end without run_last")

endmodule

// File: hw/rtl/grs_buf.sv
module grs_buf
    import grs_pkg::*;
#(
    parameter int DEPTH = MAX_GROUP_DEF,
    parameter int DW    = DATA_WIDTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    // Group storage, one write and one registered read per cycle.
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read, so it can sit on the output.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
